// File: src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, switched off while reset is asserted (active low)
`define GNCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that is also checked during reset
`define GNCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define GNCA_ASSERT(label, clk, rst_n, prop, msg)
`define GNCA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: src/gnca_pkg.sv
// Package for the grid nearest-cell averager: widths, codes, beat types
// and the averaging helper. No dependencies.
package gnca_pkg;

    localparam int GRID_SIDE_DEF   = 20;
    localparam int VALUE_COUNT_DEF = 4;
    localparam int IN_VALUES       = 4;
    localparam int VAL_W           = 32;
    localparam int COORD_W         = 32;
    localparam int CS_W            = 31;
    localparam int CELL_NUM_W      = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE  = 2'd2;

    // Item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CS_W-1:0] CELL_SIZE_RST = 31'd65536;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [VAL_W-1:0]   value_a;
        logic signed [VAL_W-1:0]   value_b;
        logic signed [VAL_W-1:0]   value_c;
        logic signed [VAL_W-1:0]   value_d;
        logic [CELL_NUM_W-1:0]     read_cell;
    } gnca_req_t;

    typedef struct packed {
        logic [CELL_NUM_W-1:0]     cell_number;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic                      occupied;
        logic signed [VAL_W-1:0]   out_value_a;
        logic signed [VAL_W-1:0]   out_value_b;
        logic signed [VAL_W-1:0]   out_value_c;
        logic signed [VAL_W-1:0]   out_value_d;
    } gnca_rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } gnca_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic centre;
        logic update;
    } gnca_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } gnca_stat_t;

    // Mean of two signed words, rounding toward minus infinity
    function automatic logic [VAL_W-1:0] gnca_avg(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return s[VAL_W:1];
    endfunction

endpackage

// File: src/gnca_ifs.sv
// Valid/ready channel interfaces for items, results and configuration.
// Depends on gnca_pkg for the beat types.
interface gnca_req_if import gnca_pkg::*; ();
    logic      valid;
    logic      ready;
    gnca_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gnca_rsp_if import gnca_pkg::*; ();
    logic      valid;
    logic      ready;
    gnca_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gnca_cfg_if import gnca_pkg::*; ();
    logic      valid;
    logic      ready;
    gnca_cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/grid_nearest_cell_averager.sv
// Top level of the grid nearest-cell averager; ties the sequencer to the
// datapath. Depends on gnca_pkg, gnca_ifs, gnca_ctrl, gnca_dp, assert_macros.svh.
//
// Usage:
//   req carries one item per beat: an add (point and values) or a read of
//   one cell. rsp returns exactly one result beat per item. cfg writes the
//   grid origin and cell size; it is always ready. It must be written only
//   while the block is idle; the block itself does not enforce this.
//   The item is loaded at its accepting edge, then passes GRID_SIDE - 1
//   boundary scan steps (for an add, one compare of the running boundary
//   per axis per cycle), a centre step for the centre multiply and cell
//   read, and an update step for the read-modify-write, which registers
//   its result and holds while the output register is still full.
//   Items are taken one at a time: a new one only after the last update.
//   After reset the occupied flags are swept clear, one cell a cycle,
//   through all GRID_SIDE * GRID_SIDE cells; req.ready stays low meanwhile.
//   The result waits in an output register. A new item can be taken while
//   it waits; that item then holds before its update until rsp takes the
//   waiting beat.
`include "assert_macros.svh"

module grid_nearest_cell_averager import gnca_pkg::*; #(
    parameter int GRID_SIDE   = GRID_SIDE_DEF,
    parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gnca_req_if.sink    req,
    gnca_rsp_if.source  rsp,
    gnca_cfg_if.sink    cfg
);

    gnca_cmd_t  cmd;
    gnca_stat_t stat;
    logic       in_ready;

    assign req.ready = in_ready;

    // Sequencer
    gnca_ctrl #(
        .GRID_SIDE (GRID_SIDE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    gnca_dp #(
        .GRID_SIDE   (GRID_SIDE),
        .VALUE_COUNT (VALUE_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cfg      (cfg),
        .rsp      (rsp),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Checks
    `GNCA_ASSERT(a_busy_after_accept, clk, rst_n, (req.valid && req.ready) |=> !req.ready, "ready stayed high after an accepted beat")
    `GNCA_ASSERT(a_no_accept_in_clear, clk, rst_n, cmd.clear |-> !req.ready, "item taken during the clearing pass")
    `GNCA_ASSERT(a_update_shows_result, clk, rst_n, cmd.update |=> rsp.valid, "cell update did not present a result")
    `GNCA_ASSERT(a_result_from_update, clk, rst_n, $rose(rsp.valid) |-> $past(cmd.update), "result appeared without a cell update")

endmodule

// File: src/gnca_ctrl.sv
// Sequencer for the averager: clearing pass, boundary scan, centre and
// cell update steps. Depends on gnca_pkg.
module gnca_ctrl import gnca_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  gnca_stat_t stat,
    output gnca_cmd_t  cmd
);

    localparam int STEP_W = (GRID_SIDE > 2) ? $clog2(GRID_SIDE - 1) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'((GRID_SIDE > 1) ? GRID_SIDE - 2 : 0);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CENTRE,
        ST_UPDATE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = (GRID_SIDE > 1) ? ST_SCAN : ST_CENTRE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_CENTRE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_CENTRE:
            begin
                cmd.centre = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: src/gnca_dp.sv
// Datapath for the averager: configuration registers, boundary compare,
// centre arithmetic, cell memories and result register. Depends on gnca_pkg.
module gnca_dp import gnca_pkg::*; #(
    parameter int GRID_SIDE   = GRID_SIDE_DEF,
    parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gnca_req_t         req_data,
    gnca_cfg_if.sink          cfg,
    gnca_rsp_if.source        rsp,
    input  gnca_cmd_t         cmd,
    output gnca_stat_t        stat
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IDX_W  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int BND_W  = CS_W + IDX_W;
    localparam int CMP_W  = COORD_W + 1 + IDX_W;
    localparam int EXT_W  = (CELL_W > CELL_NUM_W) ? CELL_W : CELL_NUM_W;
    localparam int NV     = (VALUE_COUNT < IN_VALUES) ? VALUE_COUNT : IN_VALUES;

    // Configuration registers
    logic [COORD_W-1:0] x_min_reg;
    logic [COORD_W-1:0] y_min_reg;
    logic [CS_W-1:0]    cs_reg;

    // Item registers
    logic                                kind_reg;
    logic [IN_VALUES-1:0][VAL_W-1:0]     in_vals_reg;
    logic [COORD_W:0]                    dx_reg, dy_reg;
    logic [BND_W-1:0]                    bnd_reg;
    logic [IDX_W-1:0]                    col_reg, row_reg;
    logic [CELL_W-1:0]                   rem_reg;
    logic [CELL_W-1:0]                   cell_reg;
    logic [COORD_W-1:0]                  cx_reg, cy_reg;
    logic [VALUE_COUNT-1:0][VAL_W-1:0]   vals_rd_reg;
    logic                                occ_rd_reg;
    logic [CELL_W-1:0]                   clr_reg;
    gnca_rsp_t                           rsp_reg;
    logic                                out_valid_reg;

    // Cell memories
    logic [VALUE_COUNT-1:0][VAL_W-1:0]   val_mem [CELLS];
    logic                                occ_mem [CELLS];

    logic [EXT_W-1:0]                    rc_ext;
    logic [CELL_W-1:0]                   rc_clamped;
    logic                                hit_x, hit_y, rem_hit;
    logic [IDX_W-1:0]                    col_eff;
    logic [CELL_W-1:0]                   cell_comb;
    logic [BND_W-1:0]                    prod_x, prod_y;
    logic [COORD_W-1:0]                  half_cs;
    logic [VALUE_COUNT-1:0][VAL_W-1:0]   nv_vals, new_vals;
    logic [IN_VALUES-1:0][VAL_W-1:0]     res_vals;
    logic                                is_add;

    assign cfg.ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            y_min_reg <= '0;
            cs_reg    <= CELL_SIZE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_GRID_X_MIN: x_min_reg <= cfg.data.value;
                CFG_GRID_Y_MIN: y_min_reg <= cfg.data.value;
                CFG_CELL_SIZE:  cs_reg    <= cfg.data.value[CS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp the read cell number to the last cell
    assign rc_ext     = EXT_W'(req_data.read_cell);
    assign rc_clamped = (rc_ext >= EXT_W'(CELLS)) ? CELL_W'(CELLS - 1) : CELL_W'(rc_ext);

    // Boundary compares for one scan step
    assign hit_x   = $signed({{IDX_W{dx_reg[COORD_W]}}, dx_reg}) > $signed({2'b00, bnd_reg});
    assign hit_y   = $signed({{IDX_W{dy_reg[COORD_W]}}, dy_reg}) > $signed({2'b00, bnd_reg});
    assign rem_hit = (rem_reg >= CELL_W'(GRID_SIDE));
    assign is_add  = (kind_reg == KIND_ADD);

    // Cell index and centre products
    assign col_eff   = is_add ? col_reg : IDX_W'(rem_reg);
    assign cell_comb = CELL_W'(row_reg) * CELL_W'(GRID_SIDE) + CELL_W'(col_eff);
    assign prod_x    = BND_W'(col_eff) * BND_W'(cs_reg);
    assign prod_y    = BND_W'(row_reg) * BND_W'(cs_reg);
    assign half_cs   = COORD_W'(cs_reg >> 1);

    // Load, scan and centre steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= req_data.kind;
            in_vals_reg <= {req_data.value_d, req_data.value_c,
                            req_data.value_b, req_data.value_a};
            dx_reg      <= {req_data.point_x[COORD_W-1], req_data.point_x}
                         - {x_min_reg[COORD_W-1], x_min_reg};
            dy_reg      <= {req_data.point_y[COORD_W-1], req_data.point_y}
                         - {y_min_reg[COORD_W-1], y_min_reg};
            bnd_reg     <= BND_W'(cs_reg);
            col_reg     <= '0;
            row_reg     <= '0;
            rem_reg     <= rc_clamped;
        end
        else if (cmd.scan)
        begin
            bnd_reg <= bnd_reg + BND_W'(cs_reg);
            if (is_add)
            begin
                if (hit_x)
                begin
                    col_reg <= col_reg + 1'b1;
                end
                if (hit_y)
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else if (rem_hit)
            begin
                rem_reg <= rem_reg - CELL_W'(GRID_SIDE);
                row_reg <= row_reg + 1'b1;
            end
        end
        else if (cmd.centre)
        begin
            cell_reg <= cell_comb;
            cx_reg   <= x_min_reg + prod_x[COORD_W-1:0] + half_cs;
            cy_reg   <= y_min_reg + prod_y[COORD_W-1:0] + half_cs;
        end
    end

    // Read the addressed cell
    always_ff @(posedge clk)
    begin
        if (cmd.centre)
        begin
            vals_rd_reg <= val_mem[cell_comb];
            occ_rd_reg  <= occ_mem[cell_comb];
        end
    end

    // New cell values and result fields
    always_comb
    begin
        nv_vals  = '0;
        res_vals = '0;
        for (int i = 0; i < NV; i++)
        begin
            nv_vals[i] = in_vals_reg[i];
        end
        for (int v = 0; v < VALUE_COUNT; v++)
        begin
            new_vals[v] = occ_rd_reg ? gnca_avg(vals_rd_reg[v], nv_vals[v]) : nv_vals[v];
        end
        for (int i = 0; i < NV; i++)
        begin
            if (is_add)
            begin
                res_vals[i] = new_vals[i];
            end
            else if (occ_rd_reg)
            begin
                res_vals[i] = vals_rd_reg[i];
            end
        end
    end

    // Write back the new (averaged or first) values on an add
    always_ff @(posedge clk)
    begin
        if (cmd.update && is_add)
        begin
            val_mem[cell_reg] <= new_vals;
        end
    end

    // Occupied flags: clearing pass, then set on add
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            occ_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.update && is_add)
        begin
            occ_mem[cell_reg] <= 1'b1;
        end
    end

    // Advance the clearing address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rsp_reg.cell_number <= CELL_NUM_W'(cell_reg);
            rsp_reg.center_x    <= cx_reg;
            rsp_reg.center_y    <= cy_reg;
            rsp_reg.occupied    <= is_add | occ_rd_reg;
            rsp_reg.out_value_a <= res_vals[0];
            rsp_reg.out_value_b <= res_vals[1];
            rsp_reg.out_value_c <= res_vals[2];
            rsp_reg.out_value_d <= res_vals[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.data        = rsp_reg;
    assign stat.out_free   = !out_valid_reg || rsp.ready;
    assign stat.clear_last = (clr_reg == CELL_W'(CELLS - 1));

endmodule
